FILE: rtl/lsb_pixel_stego_embed_extract_assert.svh
// Assertion macros shared by the checker of the LSB steganography block.
`ifndef LSB_PIXEL_STEGO_EMBED_EXTRACT_ASSERT_SVH
`define LSB_PIXEL_STEGO_EMBED_EXTRACT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LSBSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSBSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lsbse_pkg.sv
// Types and constants shared by the LSB steganography block and its checker.
`timescale 1ns / 1ps
package lsbse_pkg;

   // Width of one color channel and of one message byte.
   localparam int CHAN_W = 8;

   // Request word layout.
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;

   // Response word layout: three channels, byte_ready, extracted_byte, finished,
   // padded to whole bytes.
   localparam int RSP_DATA_W = 40;

   // Command carried in the request tuser field.
   typedef enum logic [REQ_USER_W-1:0] {
      CMD_RESTART = 2'd0,
      CMD_LOAD    = 2'd1,
      CMD_PIXEL   = 2'd2
   } command_type;

   // Operating mode held in the configuration register.
   typedef enum logic {
      MODE_EMBED   = 1'b0,
      MODE_EXTRACT = 1'b1
   } mode_type;

endpackage

FILE: rtl/lsbse_msg_store.sv
// Message buffer: one write port and two registered read ports with write bypass.
`timescale 1ns / 1ps
module lsbse_msg_store
   import lsbse_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CHAN_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [CHAN_W-1:0] rd_data_a,
   output logic [CHAN_W-1:0] rd_data_b
);

   logic [CHAN_W-1:0] mem_ff [DEPTH];
   logic [CHAN_W-1:0] rd_a_ff;
   logic [CHAN_W-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports; a write to the same address in this cycle is forwarded.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr_a)) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (wr_en && (wr_addr == rd_addr_b)) begin
         rd_b_ff <= wr_data;
      end else begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/lsb_pixel_stego_embed_extract.sv
// Top level of the LSB steganography embed and extract block.
`timescale 1ns / 1ps
// LSB steganography on 8-bit three-channel pixels in raster order. Each request
// word carries a command in tuser: restart clears the message and all pointers,
// load appends a byte to the message buffer (bytes beyond MESSAGE_DEPTH are
// dropped), and pixel produces exactly one response word. In embed mode
// (csr_wr_data 0) the message and a zero terminator are written MSB first into
// the LSBs of channels 0, 1 and 2; in extract mode (1) channel LSBs are packed
// into bytes and each non-zero byte is reported until the first zero byte sets
// finished. The block takes one word per clock unless the response stalls; each
// response is registered in the cycle after its pixel. The rate is set by the
// two-read-port message buffer, addressed from the next bit pointer so the two
// bytes a pixel may touch are already registered when it arrives. The buffer
// needs no clearing pass after reset. Write the mode register only while idle.
module lsb_pixel_stego_embed_extract
   import lsbse_pkg::*;
#(
   parameter int MESSAGE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration: mode, 0 embed, 1 extract.
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] message_byte, [15:8] channel_zero_in, [23:16] channel_one_in,
   // [31:24] channel_two_in
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [REQ_USER_W-1:0] req_tuser,
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] channel_zero_out, [15:8] channel_one_out, [23:16] channel_two_out,
   // [24] byte_ready, [32:25] extracted_byte, [33] finished, [39:34] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Widths that follow from the buffer depth.
   localparam int AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
   localparam int LW = $clog2(MESSAGE_DEPTH + 1);
   localparam int BW = $clog2((MESSAGE_DEPTH + 1) * 8 + 1);
   localparam int IW = BW - 3;
   localparam logic [LW-1:0] DEPTH_LEN = LW'(MESSAGE_DEPTH);
   localparam logic [IW-1:0] DEPTH_IDX = IW'(MESSAGE_DEPTH);

   // State.
   mode_type          mode_ff;
   logic [LW-1:0]     len_ff, len_in;
   logic [BW-1:0]     bp_ff, bp_in;
   logic [CHAN_W-1:0] gs_ff, gs_in;
   logic [2:0]        gc_ff, gc_in;
   logic              done_ff, done_in;

   // Response register.
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Handshake.
   logic        accept;
   command_type cmd;
   logic        is_restart, is_load, is_pixel;

   // Message buffer ports.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [IW-1:0]     next_idx0, next_idx1;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic [CHAN_W-1:0] rd_data_a, rd_data_b;

   // Pixel datapath.
   logic [CHAN_W-1:0] ch_in  [3];
   logic [CHAN_W-1:0] ch_out [3];
   logic [BW-1:0]     total;
   logic [IW-1:0]     idx0, idx1;
   logic [15:0]       window;
   logic [BW-1:0]     bp_next;
   logic [3:0]        bit_off;
   logic [CHAN_W-1:0] sh_next;
   logic [2:0]        gc_next;
   logic              dn_next;
   logic              byte_ready;
   logic [CHAN_W-1:0] extracted_byte;
   logic              finished;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = command_type'(req_tuser);

   // Decode the command of the incoming word.
   always_comb begin
      is_restart = 1'b0;
      is_load    = 1'b0;
      is_pixel   = 1'b0;
      case (cmd)
         CMD_RESTART: is_restart = accept;
         CMD_LOAD:    is_load    = accept;
         CMD_PIXEL:   is_pixel   = accept;
         default: begin
            is_restart = 1'b0;
         end
      endcase
   end

   assign ch_in[0] = req_tdata[15:8];
   assign ch_in[1] = req_tdata[23:16];
   assign ch_in[2] = req_tdata[31:24];

   // Embedding: the pixel's bits come from the byte at the bit pointer and the next one.
   assign total  = (BW'(len_ff) + BW'(1)) << 3;
   assign idx0   = bp_ff[BW-1:3];
   assign idx1   = idx0 + IW'(1);
   assign window = {(idx0 < IW'(len_ff)) ? rd_data_a : 8'h00,
                    (idx1 < IW'(len_ff)) ? rd_data_b : 8'h00};

   always_comb begin
      bp_next = bp_ff;
      bit_off = {1'b0, bp_ff[2:0]};
      for (int k = 0; k < 3; k++) begin
         ch_out[k] = ch_in[k];
      end
      if (mode_ff == MODE_EMBED) begin
         for (int k = 0; k < 3; k++) begin
            if (bp_next < total) begin
               ch_out[k] = {ch_in[k][CHAN_W-1:1], window[4'd15 - bit_off]};
               bp_next   = bp_next + BW'(1);
            end
            bit_off = bit_off + 4'd1;
         end
      end
   end

   // Extraction: shift in three LSBs; at most one byte completes per pixel.
   always_comb begin
      sh_next        = gs_ff;
      gc_next        = gc_ff;
      dn_next        = done_ff;
      byte_ready     = 1'b0;
      extracted_byte = '0;
      for (int k = 0; k < 3; k++) begin
         sh_next = {sh_next[CHAN_W-2:0], ch_in[k][0]};
         gc_next = gc_next + 3'd1;
         if ((gc_next == 3'd0) && !dn_next) begin
            if (sh_next == '0) begin
               dn_next = 1'b1;
            end else begin
               byte_ready     = 1'b1;
               extracted_byte = sh_next;
            end
         end
      end
   end

   // Next state.
   always_comb begin
      len_in  = len_ff;
      bp_in   = bp_ff;
      gs_in   = gs_ff;
      gc_in   = gc_ff;
      done_in = done_ff;
      if (is_restart) begin
         len_in  = '0;
         bp_in   = '0;
         gs_in   = '0;
         gc_in   = '0;
         done_in = 1'b0;
      end else if (is_load) begin
         if (len_ff < DEPTH_LEN) begin
            len_in = len_ff + LW'(1);
         end
      end else if (is_pixel) begin
         if (mode_ff == MODE_EMBED) begin
            bp_in   = bp_next;
            done_in = (bp_next >= total);
         end else begin
            gs_in   = sh_next;
            gc_in   = gc_next;
            done_in = dn_next;
         end
      end
   end

   // Buffer addressing follows the next bit pointer.
   assign wr_en     = is_load && (len_ff < DEPTH_LEN);
   assign wr_addr   = AW'(len_ff);
   assign next_idx0 = bp_in[BW-1:3];
   assign next_idx1 = next_idx0 + IW'(1);
   assign rd_addr_a = (next_idx0 < DEPTH_IDX) ? AW'(next_idx0) : '0;
   assign rd_addr_b = (next_idx1 < DEPTH_IDX) ? AW'(next_idx1) : '0;

   lsbse_msg_store #(
      .DEPTH (MESSAGE_DEPTH),
      .AW    (AW)
   ) u_msg_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_tdata[7:0]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Response word.
   assign finished    = done_in;
   assign rsp_data_in = {6'd0, finished, extracted_byte & {CHAN_W{mode_ff == MODE_EXTRACT}},
                         byte_ready && (mode_ff == MODE_EXTRACT),
                         ch_out[2], ch_out[1], ch_out[0]};

   // Control state and mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EMBED;
         len_ff       <= '0;
         bp_ff        <= '0;
         gs_ff        <= '0;
         gc_ff        <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         len_ff  <= len_in;
         bp_ff   <= bp_in;
         gs_ff   <= gs_in;
         gc_ff   <= gc_in;
         done_ff <= done_in;
         if (is_pixel) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (is_pixel) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/lsbse_checker.sv
// Port-level checker for the LSB steganography block, bound to the top level.
`timescale 1ns / 1ps
`include "lsb_pixel_stego_embed_extract_assert.svh"
module lsbse_checker
   import lsbse_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_take;
   logic rsp_free;

   assign req_take = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid || rsp_tready;

   // A stalled response word holds.
   `LSBSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // A reported byte is non-zero and comes before finished.
   `LSBSE_ASSERT_SAME(a_byte_ok, clock, reset, rsp_tvalid && rsp_tdata[24], !rsp_tdata[33] && (rsp_tdata[32:25] != 8'd0), "bad extracted byte")

   // Restart and load words produce no response.
   `LSBSE_ASSERT_NEXT(a_no_rsp, clock, reset, req_take && (req_tuser != CMD_PIXEL) && rsp_free, !rsp_tvalid, "response without a pixel")

   // Every pixel word produces a response in the next cycle.
   `LSBSE_ASSERT_NEXT(a_pixel_rsp, clock, reset, req_take && (req_tuser == CMD_PIXEL) && rsp_free, rsp_tvalid, "pixel without a response")

endmodule

bind lsb_pixel_stego_embed_extract lsbse_checker u_lsbse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/tb_lsb_pixel_stego_embed_extract.sv
// Self-checking testbench for the LSB pixel steganography embed and extract block.
`timescale 1ns / 1ps
module tb_lsb_pixel_stego_embed_extract;
   import lsbse_pkg::*;

   localparam int MSG_DEPTH = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Response word as a packed struct, laid out exactly like rsp_tdata.
   typedef struct packed {
      logic [5:0] pad;
      logic       finished;
      logic [7:0] extracted;
      logic       byte_ready;
      logic [7:0] ch2;
      logic [7:0] ch1;
      logic [7:0] ch0;
   } pixel_result_type;

   typedef logic [7:0] byte_queue_type[$];

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic                  csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Model of the block's state, updated as words are accepted.
   logic [7:0]       msg_store [MSG_DEPTH];
   int unsigned      msg_len = 0;
   int unsigned      bit_ptr = 0;
   logic [7:0]       gather_sh = '0;
   logic [2:0]       gather_cnt = '0;
   logic             done_flag = 1'b0;
   mode_type         cur_mode = MODE_EMBED;
   pixel_result_type expected_pixels[$];
   pixel_result_type last_pixel;

   // Stimulus knobs and run statistics.
   int unsigned sender_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_toggle = 1'b0;
   int unsigned words_sent = 0;
   int unsigned pixels_checked = 0;
   int unsigned bytes_reported = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   lsb_pixel_stego_embed_extract #(
      .MESSAGE_DEPTH(MSG_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Embeds the next message or terminator bit into one channel LSB.
   function automatic logic [7:0] embed_channel_bit(input logic [7:0] chan,
                                                    input int unsigned total_bits);
      int unsigned idx;
      logic [7:0]  src;
      logic        hidden;
      if (bit_ptr >= total_bits) return chan;
      idx = bit_ptr >> 3;
      src = (idx < msg_len) ? msg_store[idx] : 8'h00;
      hidden = src[7 - (bit_ptr & 7)];
      bit_ptr++;
      return {chan[7:1], hidden};
   endfunction

   // Shifts one channel LSB into the gathered byte; returns 1 on a reportable byte.
   function automatic logic gather_channel_bit(input logic lsb, inout logic [7:0] found);
      gather_sh = {gather_sh[6:0], lsb};
      gather_cnt = gather_cnt + 3'd1;
      if (gather_cnt != 3'd0 || done_flag) return 1'b0;
      if (gather_sh == 8'h00) begin
         done_flag = 1'b1;
         return 1'b0;
      end
      found = gather_sh;
      return 1'b1;
   endfunction

   // Applies one accepted request word to the state and queues any expected pixel.
   task automatic stego_predict(input logic [1:0] cmd, input logic [7:0] msg_byte,
                                input logic [7:0] c0, input logic [7:0] c1,
                                input logic [7:0] c2);
      pixel_result_type res;
      int unsigned      total_bits;
      logic [7:0]       found;
      logic             ready;
      case (cmd)
         CMD_RESTART: begin
            msg_len = 0;
            bit_ptr = 0;
            gather_sh = '0;
            gather_cnt = '0;
            done_flag = 1'b0;
         end
         CMD_LOAD: begin
            if (msg_len < MSG_DEPTH) begin
               msg_store[msg_len] = msg_byte;
               msg_len++;
            end
         end
         CMD_PIXEL: begin
            res = '0;
            found = 8'h00;
            ready = 1'b0;
            if (cur_mode == MODE_EMBED) begin
               total_bits = (msg_len + 1) * 8;
               res.ch0 = embed_channel_bit(c0, total_bits);
               res.ch1 = embed_channel_bit(c1, total_bits);
               res.ch2 = embed_channel_bit(c2, total_bits);
               done_flag = (bit_ptr >= total_bits);
            end else begin
               res.ch0 = c0;
               res.ch1 = c1;
               res.ch2 = c2;
               if (gather_channel_bit(c0[0], found)) ready = 1'b1;
               if (gather_channel_bit(c1[0], found)) ready = 1'b1;
               if (gather_channel_bit(c2[0], found)) ready = 1'b1;
               res.byte_ready = ready;
               res.extracted = ready ? found : 8'h00;
            end
            res.finished = done_flag;
            expected_pixels.push_back(res);
            last_pixel = res;
         end
         default: begin
            // The unused command leaves everything as it is.
         end
      endcase
   endtask

   // Offers one request word, with random idle cycles ahead of it, and waits for it to be taken.
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] msg_byte,
                            input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {c2, c1, c0, msg_byte};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      stego_predict(cmd, msg_byte, c0, c1, c2);
   endtask

   task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
      send_word(CMD_PIXEL, 8'($urandom), c0, c1, c2);
   endtask

   task automatic send_load(input logic [7:0] msg_byte);
      send_word(CMD_LOAD, msg_byte, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_restart();
      send_word(CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // A word with any command and any content, used to break up sequences.
   task automatic send_noise();
      send_word(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Message bytes with the extremes and zero showing up often.
   function automatic logic [7:0] random_message_byte();
      case ($urandom_range(7, 0))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Sends pixels whose channel LSBs carry the given bytes, MSB first.
   task automatic send_hidden_bytes(input byte_queue_type hidden);
      logic       lsbs[$];
      logic [2:0] trio;
      foreach (hidden[i])
         for (int k = 7; k >= 0; k--) lsbs.push_back(hidden[i][k]);
      while (lsbs.size() != 0) begin
         for (int k = 0; k < 3; k++)
            trio[k] = (lsbs.size() != 0) ? lsbs.pop_front() : 1'($urandom);
         send_pixel({7'($urandom), trio[0]}, {7'($urandom), trio[1]},
                    {7'($urandom), trio[2]});
      end
   endtask

   // Stops offering words and waits until every expected pixel has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the mode register while the block is idle.
   task automatic set_mode(input mode_type m);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      cur_mode = m;
      csr_wr_en <= 1'b0;
   endtask

   // Embedding with an empty message, extreme bytes, an ignored command and a late load.
   task automatic test_embed_directed();
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_restart();
      send_load(8'hFF);
      send_load(8'h00);
      send_load(8'h80);
      send_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      for (int i = 0; i < 12; i++) begin
         if (i % 2 == 0) send_pixel(8'h00, 8'hFF, 8'h00);
         else send_pixel(8'hFF, 8'h00, 8'hFF);
      end
      // Loading after the terminator went out makes the message longer again.
      send_load(8'h01);
      send_pixel(8'hAA, 8'h55, 8'hAA);
      send_pixel(8'h55, 8'hAA, 8'h55);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      drain();
   endtask

   // Extraction, bytes after the terminator, an empty message and mode swaps mid-stream.
   task automatic test_extract_directed();
      set_mode(MODE_EXTRACT);
      send_restart();
      send_hidden_bytes('{8'h41, 8'hFF, 8'h01, 8'h00, 8'h7E});
      send_restart();
      send_hidden_bytes('{8'h00});
      // Gathering and embedding state survive a mode change without restart.
      send_restart();
      send_pixel(8'h01, 8'h00, 8'h01);
      set_mode(MODE_EMBED);
      send_load(8'hC3);
      send_pixel(8'h00, 8'h00, 8'h00);
      set_mode(MODE_EXTRACT);
      send_hidden_bytes('{8'h5A, 8'h00});
      set_mode(MODE_EMBED);
   endtask

   // The receiver holds off for a long time while the sender keeps offering pixels.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      stall_pct = 0;
      send_restart();
      repeat (3) send_load(random_message_byte());
      hold_toggle = ~hold_toggle;
      repeat (60) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      drain();
   endtask

   // Fills the message buffer past its depth and embeds all of it plus the terminator.
   task automatic test_full_buffer();
      sender_idle_pct = 25;
      stall_pct = 25;
      send_restart();
      repeat (MSG_DEPTH) send_load(8'($urandom_range(255, 1)));
      repeat (4) send_load(random_message_byte());
      repeat ((MSG_DEPTH + 1) * 8 / 3 + 3) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
      drain();
   endtask

   // One embed then extract round trip with random content and occasional noise.
   task automatic run_session();
      pixel_result_type stego[$];
      int unsigned      n_bytes;
      int unsigned      n_pix;
      send_restart();
      n_bytes = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 0);
      repeat (n_bytes) send_load(random_message_byte());
      n_pix = ((n_bytes + 1) * 8 + 2) / 3 + $urandom_range(3, 0);
      repeat (n_pix) begin
         if ($urandom_range(19, 0) == 0) send_noise();
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         stego.push_back(last_pixel);
      end
      set_mode(MODE_EXTRACT);
      if ($urandom_range(5, 0) != 0) send_restart();
      foreach (stego[i]) begin
         if ($urandom_range(29, 0) == 0) send_noise();
         send_pixel(stego[i].ch0, stego[i].ch1, stego[i].ch2);
      end
      repeat ($urandom_range(3, 0)) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      set_mode(MODE_EMBED);
   endtask

   // Random round trips under each idling pattern in turn.
   task automatic test_random_sessions();
      int unsigned phase_end;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 63; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 63; end
            default: begin sender_idle_pct = 38; stall_pct = 38; end
         endcase
         phase_end = words_sent + 40;
         while (words_sent < phase_end) run_session();
      end
      drain();
   endtask

   // Response side: random stalls, plus a long hold-off on request.
   initial begin
      int unsigned hold_left;
      logic        seen_toggle;
      hold_left = 0;
      seen_toggle = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   // Each accepted response word is compared with the oldest expected pixel.
   always @(posedge clock) begin
      pixel_result_type want;
      pixel_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = pixel_result_type'(rsp_tdata);
         want = '0;
         pixels_checked++;
         if (got.byte_ready === 1'b1) bytes_reported++;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response word with no pixel pending: %h", $realtime, rsp_tdata);
         end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch, expected ch %h %h %h ready %b byte %h fin %b pad %h",
                           $realtime, want.ch0, want.ch1, want.ch2, want.byte_ready,
                           want.extracted, want.finished, want.pad);
                  $display("%0t:           actual   ch %h %h %h ready %b byte %h fin %b pad %h",
                           $realtime, got.ch0, got.ch1, got.ch2, got.byte_ready,
                           got.extracted, got.finished, got.pad);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d pixels pending.", cycle_count,
                  expected_pixels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_RESTART;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_embed_directed();
      test_extract_directed();
      test_backpressure();
      test_full_buffer();
      test_random_sessions();
      drain();
      repeat (8) @(posedge clock);
      $display("Covered %0d request words and %0d pixel responses, %0d with a recovered byte.",
               words_sent, pixels_checked, bytes_reported);
      $display("Both modes, restarts, buffer overflow, unused commands and a long stall ran; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lsbse_pkg.sv
rtl/lsbse_msg_store.sv
rtl/lsb_pixel_stego_embed_extract.sv
rtl/lsbse_checker.sv
test/tb_lsb_pixel_stego_embed_extract.sv
